/* rtl/nsfb_pkg.sv */
package nsfb_pkg;

  // default ring store depth and the widest store the block supports
  localparam int BUF_DEPTH_DEF = 256;
  localparam int ADDR_MAX_W    = 12;

  localparam int BYTE_W = 8;
  localparam int PEND_W = 8;

  // item commands
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // characters of interest
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_V      = 8'h56;
  localparam logic [BYTE_W-1:0] CH_Z      = 8'h5A;
  localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_S      = 8'h53;
  localparam logic [BYTE_W-1:0] CH_L      = 8'h4C;

  // sentence offsets at which the type filter looks
  localparam int OFS_TYPE_A = 3;
  localparam int OFS_TYPE_B = 4;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              end_of_sentence;
    logic [PEND_W-1:0] sentences_pending;
  } out_item_t;

  // write request from the fill side to the store
  typedef struct packed {
    logic                  we;
    logic                  commit;
    logic [ADDR_MAX_W-1:0] waddr;
    logic [BYTE_W-1:0]     wdata;
  } wr_t;

endpackage

/* rtl/nsfb_if.sv */
interface nsfb_in_if;
  logic               valid;
  logic               ready;
  nsfb_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface nsfb_out_if;
  logic                valid;
  logic                ready;
  nsfb_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/nsfb_fill.sv */
module nsfb_fill #(
  parameter int BUF_DEPTH = nsfb_pkg::BUF_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       byte_en,
  input  logic [nsfb_pkg::BYTE_W-1:0] data_byte,
  input  logic [$clog2(BUF_DEPTH)-1:0] drain_head,
  output nsfb_pkg::wr_t              wr
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam logic [AW:0] DEPTH_X = (AW+1)'(BUF_DEPTH);

  logic [AW-1:0] commit_head_r, commit_head_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic          in_sent_r, in_sent_nxt;

  logic [AW:0]   sum_next, sum_cur;
  logic [AW-1:0] pos_next, pos_cur;
  logic          full;
  logic          type_drop;

  // sums stay below twice the depth, so one subtract wraps them
  assign sum_next = {1'b0, commit_head_r} + {1'b0, fill_r} + (AW+1)'(1);
  assign sum_cur  = {1'b0, commit_head_r} + {1'b0, fill_r};
  assign pos_next = (sum_next >= DEPTH_X) ? AW'(sum_next - DEPTH_X) : sum_next[AW-1:0];
  assign pos_cur  = (sum_cur  >= DEPTH_X) ? AW'(sum_cur  - DEPTH_X) : sum_cur[AW-1:0];
  assign full     = (pos_next == drain_head);

  assign type_drop =
      ((fill_r == AW'(nsfb_pkg::OFS_TYPE_A)) &&
       (data_byte == nsfb_pkg::CH_V || data_byte == nsfb_pkg::CH_Z ||
        data_byte == nsfb_pkg::CH_M)) ||
      ((fill_r == AW'(nsfb_pkg::OFS_TYPE_B)) &&
       (data_byte == nsfb_pkg::CH_S || data_byte == nsfb_pkg::CH_L));

  always_comb begin
    commit_head_nxt = commit_head_r;
    fill_nxt        = fill_r;
    in_sent_nxt     = in_sent_r;
    wr.we           = 1'b0;
    wr.commit       = 1'b0;
    wr.waddr        = nsfb_pkg::ADDR_MAX_W'(pos_cur);
    wr.wdata        = data_byte;
    if (byte_en) begin
      if (full) begin
        // no room: abandon the open sentence
        fill_nxt    = '0;
        in_sent_nxt = 1'b0;
      end else if (data_byte == nsfb_pkg::CH_DOLLAR) begin
        wr.we       = 1'b1;
        wr.waddr    = nsfb_pkg::ADDR_MAX_W'(commit_head_r);
        fill_nxt    = AW'(1);
        in_sent_nxt = 1'b1;
      end else if (in_sent_r) begin
        if (type_drop) begin
          fill_nxt    = '0;
          in_sent_nxt = 1'b0;
        end else begin
          wr.we = 1'b1;
          if (data_byte == nsfb_pkg::CH_LF) begin
            wr.commit       = 1'b1;
            commit_head_nxt = pos_next;
            fill_nxt        = '0;
            in_sent_nxt     = 1'b0;
          end else begin
            fill_nxt = fill_r + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      commit_head_r <= '0;
      fill_r        <= '0;
      in_sent_r     <= 1'b0;
    end else begin
      commit_head_r <= commit_head_nxt;
      fill_r        <= fill_nxt;
      in_sent_r     <= in_sent_nxt;
    end
  end

endmodule

/* rtl/nsfb_store.sv */
module nsfb_store #(
  parameter int BUF_DEPTH = nsfb_pkg::BUF_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  nsfb_pkg::wr_t                wr,
  input  logic [$clog2(BUF_DEPTH)-1:0] raddr,
  output logic [nsfb_pkg::BYTE_W-1:0]  rd_byte
);

  localparam int AW = $clog2(BUF_DEPTH);

  logic [nsfb_pkg::BYTE_W-1:0] mem [BUF_DEPTH];
  logic [nsfb_pkg::BYTE_W-1:0] rdata_r;
  logic [nsfb_pkg::BYTE_W-1:0] byp_data_r;
  logic                        byp_r;
  logic [AW-1:0]               waddr;

  assign waddr = wr.waddr[AW-1:0];

  // read port runs every cycle on the next head address
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.wdata;
    end
    rdata_r    <= mem[raddr];
    byp_data_r <= wr.wdata;
  end

  // write-first: a write to the address being read wins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else begin
      byp_r <= wr.we && (waddr == raddr);
    end
  end

  assign rd_byte = byp_r ? byp_data_r : rdata_r;

endmodule

/* rtl/nmea_sentence_filter_buffer_core.sv */
// Channel  Dir  Payload                                              Handshake
// in_ch    in   command, data_byte                                   valid/ready
// out_ch   out  out_byte, byte_valid, end_of_sentence,               valid/ready
//               sentences_pending
//
// One item per cycle when not stalled: each item is handled in the cycle it
// is accepted and a drain result sits in the output register from the next
// cycle. Byte items give no result; every drain item gives exactly one.
// The store's registered read port always holds the byte at the read position,
// so a drain need not wait for a read.
// in_ch.ready drops only while a result waits and out_ch.ready is low.
// Synchronous active-low reset clears the pointers and counters; the store
// itself is not cleared.
module nmea_sentence_filter_buffer_core #(
  parameter int BUF_DEPTH = nsfb_pkg::BUF_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  nsfb_in_if.sink         in_ch,
  nsfb_out_if.source      out_ch
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam logic [AW:0] DEPTH_X = (AW+1)'(BUF_DEPTH);

  // handshake
  logic in_fire;
  logic byte_en;
  logic drain_en;

  // drain side state
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;       // drain_head + drain_offset
  logic [AW-1:0] drain_head_r, drain_head_nxt;
  logic [AW-1:0] pend_r, pend_nxt;           // committed, not fully drained

  logic [AW:0]   rd_inc;
  logic [AW-1:0] rd_ptr_inc;
  logic          have;                       // a committed byte is waiting
  logic          is_lf;
  logic [AW-1:0] pend_after;
  logic [15:0]   pend_wide;

  logic [nsfb_pkg::BYTE_W-1:0] cur_byte;
  nsfb_pkg::wr_t               wr;

  // result register
  logic                out_valid_r, out_valid_nxt;
  nsfb_pkg::out_item_t out_r, out_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign byte_en     = in_fire && (in_ch.payload.command == nsfb_pkg::CMD_BYTE);
  assign drain_en    = in_fire && (in_ch.payload.command == nsfb_pkg::CMD_DRAIN);

  nsfb_fill #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_fill (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .data_byte (in_ch.payload.data_byte),
    .drain_head(drain_head_r),
    .wr        (wr)
  );

  nsfb_store #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .raddr  (rd_ptr_nxt),
    .rd_byte(cur_byte)
  );

  // A drain of a committed byte advances the read position by one, LF or not,
  // so the next read address never waits on the data.
  assign rd_inc     = {1'b0, rd_ptr_r} + (AW+1)'(1);
  assign rd_ptr_inc = (rd_inc >= DEPTH_X) ? AW'(rd_inc - DEPTH_X) : rd_inc[AW-1:0];

  assign have       = (pend_r != '0);
  assign is_lf      = (cur_byte == nsfb_pkg::CH_LF);
  assign pend_after = pend_r - AW'(have && is_lf);
  assign pend_wide  = 16'(pend_after);

  always_comb begin
    rd_ptr_nxt     = rd_ptr_r;
    drain_head_nxt = drain_head_r;
    pend_nxt       = pend_r;
    if (drain_en && have) begin
      rd_ptr_nxt = rd_ptr_inc;
      pend_nxt   = pend_after;
      if (is_lf) begin
        drain_head_nxt = rd_ptr_inc;
      end
    end else if (wr.commit) begin
      pend_nxt = pend_r + AW'(1);
    end
  end

  always_comb begin
    out_nxt = out_r;
    if (drain_en) begin
      out_nxt.out_byte          = have ? cur_byte : '0;
      out_nxt.byte_valid        = have;
      out_nxt.end_of_sentence   = have && is_lf;
      // saturate the count to the field width
      out_nxt.sentences_pending = (pend_wide > 16'd255) ? 8'hFF : pend_wide[7:0];
    end
  end

  always_comb begin
    if (drain_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r     <= '0;
      drain_head_r <= '0;
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      rd_ptr_r     <= rd_ptr_nxt;
      drain_head_r <= drain_head_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

endmodule

/* bench/nsfb_sentence_checker.sv */
module nsfb_sentence_checker #(
  parameter int DEPTH = nsfb_pkg::BUF_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  nsfb_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  nsfb_pkg::out_item_t out_item,
  output int                  fail_cnt,
  output int                  open_cnt,
  output int                  checked_cnt,
  output int                  commit_cnt,
  output int                  full_drop_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the sentence store
  logic [nsfb_pkg::BYTE_W-1:0] ring [DEPTH];
  int unsigned                 fill_base;
  int unsigned                 fill_len;
  logic                        open_sent;
  int unsigned                 rd_base;
  int unsigned                 rd_len;
  int unsigned                 n_ready;

  nsfb_pkg::out_item_t drain_q [$];
  int                  fails     = 0;
  int                  checked   = 0;
  int                  commits   = 0;
  int                  full_drop = 0;

  function automatic void take_char(input logic [nsfb_pkg::BYTE_W-1:0] c);
    // store full: the byte is lost and so is the open sentence
    if ((fill_base + fill_len + 1) % DEPTH == rd_base) begin
      fill_len  = 0;
      open_sent = 1'b0;
      full_drop++;
      return;
    end
    if (c == nsfb_pkg::CH_DOLLAR) begin
      ring[fill_base] = c;
      fill_len        = 1;
      open_sent       = 1'b1;
      return;
    end
    if (!open_sent) return;
    if ((fill_len == nsfb_pkg::OFS_TYPE_A &&
         (c == nsfb_pkg::CH_V || c == nsfb_pkg::CH_Z || c == nsfb_pkg::CH_M)) ||
        (fill_len == nsfb_pkg::OFS_TYPE_B &&
         (c == nsfb_pkg::CH_S || c == nsfb_pkg::CH_L))) begin
      fill_len  = 0;
      open_sent = 1'b0;
      return;
    end
    ring[(fill_base + fill_len) % DEPTH] = c;
    if (c == nsfb_pkg::CH_LF) begin
      n_ready++;
      commits++;
      fill_base = (fill_base + fill_len + 1) % DEPTH;
      fill_len  = 0;
      open_sent = 1'b0;
    end else begin
      fill_len++;
    end
  endfunction

  function automatic nsfb_pkg::out_item_t next_drain();
    nsfb_pkg::out_item_t         r;
    logic [nsfb_pkg::BYTE_W-1:0] b;
    r = '0;
    if (n_ready == 0) return r;
    b            = ring[(rd_base + rd_len) % DEPTH];
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    if (b == nsfb_pkg::CH_LF) begin
      r.end_of_sentence = 1'b1;
      n_ready--;
      rd_base = (rd_base + rd_len + 1) % DEPTH;
      rd_len  = 0;
    end else begin
      rd_len = (rd_len + 1) % DEPTH;
    end
    r.sentences_pending = (n_ready > 255) ? 8'd255 : n_ready[nsfb_pkg::PEND_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    nsfb_pkg::out_item_t want;
    if (!rst_n) begin
      fill_base = 0;
      fill_len  = 0;
      open_sent = 1'b0;
      rd_base   = 0;
      rd_len    = 0;
      n_ready   = 0;
      drain_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_item.command == nsfb_pkg::CMD_DRAIN) drain_q.push_back(next_drain());
        else take_char(in_item.data_byte);
      end
      if (out_valid && out_ready) begin
        if (drain_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result byte %02h valid %0b eos %0b pending %0d",
                     $realtime, out_item.out_byte, out_item.byte_valid,
                     out_item.end_of_sentence, out_item.sentences_pending);
        end else begin
          want = drain_q.pop_front();
          checked++;
          if (want.out_byte !== out_item.out_byte ||
              want.byte_valid !== out_item.byte_valid ||
              want.end_of_sentence !== out_item.end_of_sentence ||
              want.sentences_pending !== out_item.sentences_pending) begin
            fails++;
            if (fails <= 10)
              $display("%0t: result %0d exp byte %02h valid %0b eos %0b pending %0d, %s",
                       $realtime, checked, want.out_byte, want.byte_valid,
                       want.end_of_sentence, want.sentences_pending,
                       $sformatf("got byte %02h valid %0b eos %0b pending %0d",
                                 out_item.out_byte, out_item.byte_valid,
                                 out_item.end_of_sentence, out_item.sentences_pending));
          end
        end
      end
    end
    fail_cnt      <= fails;
    open_cnt      <= drain_q.size();
    checked_cnt   <= checked;
    commit_cnt    <= commits;
    full_drop_cnt <= full_drop;
  end

endmodule

/* bench/tb_nmea_sentence_filter_buffer_core.sv */
module tb_nmea_sentence_filter_buffer_core;
  timeunit 1ns;
  timeprecision 1ps;

  // sentence shapes made by the random part
  localparam int FORM_ANY  = 0;  // proper sentence, any type, filtered ones too
  localparam int FORM_PASS = 1;  // proper sentence of a type that survives the filter
  localparam int FORM_RAW  = 2;  // '$' then arbitrary bytes, LF usually at the end

  localparam int ITEMS_TARGET = 560;

  logic clk = 1'b0;
  logic rst_n;

  nsfb_in_if  in_ch ();
  nsfb_out_if out_ch ();

  int fail_cnt, open_cnt, checked_cnt, commit_cnt, full_drop_cnt;

  // first four survive, the rest are dropped at offset 3 or 4
  string sent_types [10] = '{"GGA", "RMC", "GNS", "TXT",
                             "VTG", "ZDA", "MSS", "GSA", "GSV", "GLL"};

  int burst_left = 0;
  int n_items    = 0;
  int n_drains   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  nmea_sentence_filter_buffer_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  nsfb_sentence_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_item       (in_ch.payload),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_item      (out_ch.payload),
    .fail_cnt      (fail_cnt),
    .open_cnt      (open_cnt),
    .checked_cnt   (checked_cnt),
    .commit_cnt    (commit_cnt),
    .full_drop_cnt (full_drop_cnt)
  );

  // One item on the input channel. Called at a rising edge; returns at the edge
  // that accepted the item, with valid still high so back-to-back items keep it
  // up. Bursts of random length, random gaps between them.
  task automatic put_item(input logic cmd, input logic [nsfb_pkg::BYTE_W-1:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.payload <= '{command: cmd, data_byte: c};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_items++;
    if (cmd == nsfb_pkg::CMD_DRAIN) n_drains++;
  endtask

  task automatic feed_byte(input logic [nsfb_pkg::BYTE_W-1:0] c);
    put_item(nsfb_pkg::CMD_BYTE, c);
  endtask

  // data field is don't-care on a drain, so fill it with noise
  task automatic request_drain();
    put_item(nsfb_pkg::CMD_DRAIN, $urandom_range(0, 255));
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) feed_byte(s[i]);
  endtask

  // a byte, sometimes preceded by a drain so reads overlap with filling
  task automatic feed_mixed(input logic [nsfb_pkg::BYTE_W-1:0] c, input int drain_pct);
    if ($urandom_range(0, 99) < drain_pct) request_drain();
    feed_byte(c);
  endtask

  // hold the sender off until every drain result has come back
  task automatic await_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (open_cnt != 0) @(posedge clk);
  endtask

  task automatic send_sentence(input int drain_pct, input int form);
    string                       hdr;
    int                          body_len;
    logic [nsfb_pkg::BYTE_W-1:0] c;
    // mostly short bodies, now and then a long one to stress wrap-around
    body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 10);
    feed_mixed(nsfb_pkg::CH_DOLLAR, drain_pct);
    if (form == FORM_RAW) begin
      // any byte but LF; a stray '$' restarts, type letters may filter
      repeat (body_len + 2) begin
        c = $urandom_range(0, 255);
        if (c == nsfb_pkg::CH_LF) c = 8'h8A;
        feed_mixed(c, drain_pct);
      end
      if ($urandom_range(0, 3) != 0) feed_mixed(nsfb_pkg::CH_LF, drain_pct);
    end else begin
      hdr = {"GP", sent_types[(form == FORM_PASS) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 9)], ","};
      for (int i = 0; i < hdr.len(); i++) feed_mixed(hdr[i], drain_pct);
      repeat (body_len) begin
        c = $urandom_range(8'h20, 8'h7E);
        if (c == nsfb_pkg::CH_DOLLAR) c = "*";
        feed_mixed(c, drain_pct);
      end
      feed_mixed(nsfb_pkg::CH_LF, drain_pct);
    end
  endtask

  // Receiver: ready follows a mode that changes at random -- always ready,
  // mostly ready, a fixed duty pattern, or mostly stalled.
  initial begin
    int mode;
    int left;
    int tick;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      tick++;
      case (mode)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= ($urandom_range(0, 9) < 7);
        end
        2: begin
          out_ch.ready <= ((tick % 13) < 4);
        end
        default: begin
          out_ch.ready <= ($urandom_range(0, 9) < 2);
        end
      endcase
    end
  end

  // Stimulus and verdict
  initial begin
    int  drain_pct;
    bit  flooded;
    bit  paused;
    int  drops0;
    int  k;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    rst_n         = 1'b0;
    flooded       = 1'b0;
    paused        = 1'b0;
    drain_pct     = 20;
    drops0        = 0;
    k             = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---
    request_drain();               // nothing committed yet: invalid result
    feed_byte(8'h00);              // bytes outside a sentence are ignored,
    feed_byte(8'hFF);              // a bare LF included
    feed_byte(nsfb_pkg::CH_LF);
    send_text("$\n");              // shortest sentence that commits
    send_text("$GPV");             // type letter at offset 3 drops it
    send_text("$GPGS");            // type letter at offset 4 drops it
    send_text("$G$\n");            // '$' mid-sentence restarts: commits "$\n"
    repeat (5) request_drain();    // both sentences out, then empty again
    await_results();

    // --- random part ---
    while (n_items < ITEMS_TARGET) begin
      // once: fill the store with no drains until it overflows, then drain half
      if (!flooded && n_items > 120) begin
        flooded = 1'b1;
        drops0  = full_drop_cnt;
        k       = 0;
        while (full_drop_cnt == drops0 && k < 40) begin
          send_sentence(0, FORM_PASS);
          k++;
        end
        repeat (128) request_drain();
      end
      // once: let the result side catch up completely mid-run
      if (!paused && n_items > 60) begin
        paused = 1'b1;
        await_results();
      end
      case ($urandom_range(0, 11))
        0: begin
          case ($urandom_range(0, 3))
            0:       drain_pct = 0;
            1:       drain_pct = 10;
            2:       drain_pct = 40;
            default: drain_pct = 80;
          endcase
        end
        1, 2, 3, 4, 5, 6: begin
          send_sentence(drain_pct, FORM_ANY);
        end
        7, 8: begin
          send_sentence(drain_pct, FORM_RAW);
        end
        9: begin
          repeat ($urandom_range(1, 4)) feed_byte($urandom_range(0, 255));
        end
        default: begin
          repeat ($urandom_range(1, 30)) request_drain();
        end
      endcase
    end

    // drain what is still buffered so the tail is checked too
    repeat (40) request_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_cnt != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items (%0d drains); %0d drain results compared",
             n_items, n_drains, checked_cnt);
    $display("%0d sentences committed, %0d bytes lost to a full store",
             commit_cnt, full_drop_cnt);
    if (fail_cnt == 0 && open_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
